// ===== hdl/sdfc_pkg.sv =====
// shared constants and codes for the sdf csg combiner
// no dependencies; imported by sdf_csg_combiner and sdfc_isqrt_pipe
package sdfc_pkg;

  // default fixed point format, Q3.12
  localparam int FRAC_BITS_DEF  = 12;
  localparam int DIST_WIDTH_DEF = 16;

  // radius registers
  localparam int RADIUS_W = 12;
  localparam logic [RADIUS_W-1:0] CHAMFER_RADIUS_RST = 12'd205;
  localparam logic [RADIUS_W-1:0] ROUND_RADIUS_RST   = 12'd410;

  // sqrt(0.5) in Q0.32, rounded
  localparam logic [63:0] HALF_ROOT_Q32 = 64'd3037000500;

  // the root pipeline needs at least this many result bits
  localparam int ROOT_W_MIN = 2;

  typedef enum logic [2:0] {
    OP_UNION     = 3'd0,
    OP_CHAMFER   = 3'd1,
    OP_ROUND     = 3'd2,
    OP_INTERSECT = 3'd3,
    OP_SUBTRACT  = 3'd4
  } sdfc_op_t;

  typedef enum logic [0:0] {
    REG_CHAMFER_RADIUS = 1'b0,
    REG_ROUND_RADIUS   = 1'b1
  } sdfc_reg_t;

endpackage

// ===== hdl/sdfc_isqrt_pipe.sv =====
// pipelined floor square root, one result bit per stage, with a side payload
// depends on sdfc_pkg
module sdfc_isqrt_pipe #(
  parameter int ROOT_W = 14,
  parameter int PAY_W  = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2*ROOT_W-1:0]   rad_in,
  input  logic [PAY_W-1:0]      pay_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ROOT_W-1:0]     root_out,
  output logic [PAY_W-1:0]      pay_out
);
  import sdfc_pkg::*;

  localparam int RAD_W = 2 * ROOT_W;

  logic [ROOT_W-1:0] vld_q;
  logic [ROOT_W-1:0] go;
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [PAY_W-1:0]  pay_q  [ROOT_W];
  // remainder and unused radicand bits are not needed after the last stage
  logic [ROOT_W:0]   rem_q  [ROOT_W-1];
  logic [RAD_W-1:0]  rad_q  [ROOT_W-1];

  assign in_stall  = !go[0];
  assign out_valid = vld_q[ROOT_W-1];
  assign root_out  = root_q[ROOT_W-1];
  assign pay_out   = pay_q[ROOT_W-1];

  genvar s;
  generate
    for (s = 0; s < ROOT_W; s++) begin : g_stage
      logic              prev_vld;
      logic [ROOT_W:0]   prev_rem;
      logic [ROOT_W-1:0] prev_root;
      logic [RAD_W-1:0]  prev_rad;
      logic [PAY_W-1:0]  prev_pay;
      logic [ROOT_W+1:0] shifted;
      logic [ROOT_W+1:0] trial;
      logic              fits;
      logic [ROOT_W+1:0] rem_next;
      logic [ROOT_W-1:0] root_next;

      if (s == 0) begin : g_first
        assign prev_vld  = in_valid;
        assign prev_rem  = '0;
        assign prev_root = '0;
        assign prev_rad  = rad_in;
        assign prev_pay  = pay_in;
      end else begin : g_next
        assign prev_vld  = vld_q[s-1];
        assign prev_rem  = rem_q[s-1];
        assign prev_root = root_q[s-1];
        assign prev_rad  = rad_q[s-1];
        assign prev_pay  = pay_q[s-1];
      end

      if (s == ROOT_W - 1) begin : g_go_last
        assign go[s] = !vld_q[s] || !out_stall;
      end else begin : g_go_mid
        assign go[s] = !vld_q[s] || go[s+1];
      end

      // bring down two radicand bits and try root*4+1
      always_comb begin
        shifted   = {prev_rem[ROOT_W-1:0], prev_rad[RAD_W-1 -: 2]};
        trial     = {prev_root, 2'b01};
        fits      = (shifted >= trial);
        rem_next  = fits ? (shifted - trial) : shifted;
        root_next = {prev_root[ROOT_W-2:0], fits};
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld_q[s] <= 1'b0;
        end else if (go[s]) begin
          vld_q[s] <= prev_vld;
        end
      end

      always_ff @(posedge clk) begin
        if (go[s]) begin
          root_q[s] <= root_next;
          pay_q[s]  <= prev_pay;
        end
      end

      if (s < ROOT_W - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (go[s]) begin
            rem_q[s] <= rem_next[ROOT_W:0];
            rad_q[s] <= {prev_rad[RAD_W-3:0], 2'b00};
          end
        end
      end else begin : g_tail
        // final remainder is dropped; only the floor of the root matters
        logic unused_rem;
        assign unused_rem = ^rem_next;
      end
    end
  endgenerate

endmodule

// ===== hdl/sdf_csg_combiner.sv =====
// top level of the sdf csg combiner: operand decode, chamfer product, squares,
// root pipeline and saturating output register; depends on sdfc_pkg, sdfc_isqrt_pipe
//
// Combines two signed distance samples (Q3.12 by default) under union, chamfer
// union, rounded union, intersection or subtraction. One item is accepted per
// clock while in_stall is low; results come back in order. The floor square
// root of the rounded union is a pipeline that produces one root bit per stage,
// with a root width of ROOT_W = max(DIST_WIDTH, 13) + 1. An invalid sample acts
// like a NaN: it drops out of min and max, and both samples invalid (or an op
// code above 4) gives out_valid 0 with dist_out 0. Radii are written through
// wr_en, wr_index and wr_data; the user must write them only while no item is in
// flight, as the block does not enforce it. Every result saturates to DIST_WIDTH.
module sdf_csg_combiner #(
  parameter int FRAC_BITS  = sdfc_pkg::FRAC_BITS_DEF,
  parameter int DIST_WIDTH = sdfc_pkg::DIST_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          wr_en,
  input  logic                          wr_index,
  input  logic [sdfc_pkg::RADIUS_W-1:0] wr_data,
  // item input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    op,
  input  logic signed [DIST_WIDTH-1:0]  dist_a,
  input  logic                          a_valid,
  input  logic signed [DIST_WIDTH-1:0]  dist_b,
  input  logic                          b_valid,
  // item output
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic signed [DIST_WIDTH-1:0]  dist_out,
  output logic                          out_valid
);
  import sdfc_pkg::*;

  // headroom: radius is 12 bits, so work in at least 13 bits
  localparam int HW      = (DIST_WIDTH > RADIUS_W + 1) ? DIST_WIDTH : RADIUS_W + 1;
  localparam int EXT_W   = HW + 2;            // a + b - r, -b, a, b
  localparam int PROD_W  = EXT_W + FRAC_BITS + 1;
  localparam int CAND_W  = PROD_W - FRAC_BITS;
  localparam int BASE_W  = CAND_W;
  localparam int SQ_W    = 2 * HW;
  localparam int ROOT_W  = HW + 1;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int DIFF_W  = HW + 4;
  localparam int PAY_W   = BASE_W + 1;

  // sqrt(0.5) scaled by 2^FRAC_BITS, rounded
  localparam logic [63:0] K_FULL =
    (HALF_ROOT_Q32 * (64'd1 << FRAC_BITS) + 64'h8000_0000) >> 32;
  localparam logic [FRAC_BITS-1:0] CHAMFER_K = K_FULL[FRAC_BITS-1:0];

  localparam logic [PROD_W-1:0] ROUND_HALF =
    {{(PROD_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [DIFF_W-1:0] SAT_HI =
    {{(DIFF_W-DIST_WIDTH+1){1'b0}}, {(DIST_WIDTH-1){1'b1}}};
  localparam logic signed [DIFF_W-1:0] SAT_LO =
    {{(DIFF_W-DIST_WIDTH+1){1'b1}}, {(DIST_WIDTH-1){1'b0}}};

  // radius registers
  logic [RADIUS_W-1:0] chamfer_radius;
  logic [RADIUS_W-1:0] round_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      chamfer_radius <= CHAMFER_RADIUS_RST;
      round_radius   <= ROUND_RADIUS_RST;
    end else if (wr_en) begin
      case (sdfc_reg_t'(wr_index))
        REG_CHAMFER_RADIUS: chamfer_radius <= wr_data;
        REG_ROUND_RADIUS:   round_radius   <= wr_data;
        default: ;
      endcase
    end
  end

  logic signed [EXT_W-1:0] cr_ext;
  logic signed [EXT_W-1:0] rr_ext;
  assign cr_ext = $signed({{(EXT_W-RADIUS_W){1'b0}}, chamfer_radius});
  assign rr_ext = $signed({{(EXT_W-RADIUS_W){1'b0}}, round_radius});

  // stage handshake: a stage loads when it is empty or the next one moves
  logic v1, v2, v3;
  logic go1, go2, go3;
  logic root_in_stall;
  logic root_out_valid;
  logic go_out;

  assign go_out   = !res_valid || !res_stall;
  assign go3      = !v3 || !root_in_stall;
  assign go2      = !v2 || go3;
  assign go1      = !v1 || go2;
  assign in_stall = !go1;

  // ---------------------------------------------------------------- stage 1
  // pick min/max per op, chamfer sum, rounded union clearances
  logic signed [EXT_W-1:0] a_ext, b_ext, negb;
  logic signed [EXT_W-1:0] mn, mx, sub;
  logic signed [EXT_W-1:0] base_next, sum_next;
  logic signed [EXT_W-1:0] dx, dy;
  logic [HW-1:0]           ux_next, uy_next;
  logic                    both;
  logic                    ok_next, cham_next, rnd_next;

  always_comb begin
    a_ext = EXT_W'(dist_a);
    b_ext = EXT_W'(dist_b);
    negb  = -b_ext;
    both  = a_valid && b_valid;
    mn    = both ? ((a_ext < b_ext) ? a_ext : b_ext) : (a_valid ? a_ext : b_ext);
    mx    = both ? ((a_ext > b_ext) ? a_ext : b_ext) : (a_valid ? a_ext : b_ext);
    sub   = both ? ((a_ext > negb) ? a_ext : negb) : (a_valid ? a_ext : negb);
    sum_next = a_ext + b_ext - cr_ext;
    dx    = rr_ext - a_ext;
    dy    = rr_ext - b_ext;

    ok_next   = a_valid || b_valid;
    cham_next = 1'b0;
    rnd_next  = 1'b0;
    base_next = '0;
    case (sdfc_op_t'(op))
      OP_UNION:     base_next = mn;
      OP_CHAMFER: begin
        base_next = mn;
        cham_next = both;
      end
      OP_ROUND: begin
        base_next = mn;
        rnd_next  = 1'b1;
      end
      OP_INTERSECT: base_next = mx;
      OP_SUBTRACT:  base_next = sub;
      default:      ok_next   = 1'b0;
    endcase

    // invalid samples, samples not below the round radius and other ops contribute a zero clearance term
    ux_next = (rnd_next && a_valid && (rr_ext > a_ext)) ? dx[HW-1:0] : '0;
    uy_next = (rnd_next && b_valid && (rr_ext > b_ext)) ? dy[HW-1:0] : '0;
  end

  logic                    ok1, cham1, rnd1;
  logic signed [EXT_W-1:0] base1, sum1;
  logic [HW-1:0]           ux1, uy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (go1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      ok1   <= ok_next;
      cham1 <= cham_next;
      rnd1  <= rnd_next;
      base1 <= base_next;
      sum1  <= sum_next;
      ux1   <= ux_next;
      uy1   <= uy_next;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // chamfer product, the two squares, max against the round radius
  logic signed [PROD_W-1:0] prod_next;
  logic [SQ_W-1:0]          sqx_next, sqy_next;
  logic signed [EXT_W-1:0]  base2_next;

  always_comb begin
    prod_next  = PROD_W'(sum1) * PROD_W'($signed({1'b0, CHAMFER_K}));
    sqx_next   = SQ_W'(ux1) * SQ_W'(ux1);
    sqy_next   = SQ_W'(uy1) * SQ_W'(uy1);
    base2_next = (rnd1 && (rr_ext > base1)) ? rr_ext : base1;
  end

  logic                     ok2, cham2;
  logic signed [PROD_W-1:0] prod2;
  logic [SQ_W-1:0]          sqx2, sqy2;
  logic signed [EXT_W-1:0]  base2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (go2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (go2) begin
      ok2   <= ok1;
      cham2 <= cham1;
      prod2 <= prod_next;
      sqx2  <= sqx_next;
      sqy2  <= sqy_next;
      base2 <= base2_next;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // round the chamfer product to nearest, take the min, sum the squares
  logic signed [PROD_W-1:0] prod_rnd, prod_shr;
  logic signed [CAND_W-1:0] cand;
  logic signed [BASE_W-1:0] base2_w;
  logic signed [BASE_W-1:0] base3_next;
  logic [RAD_W-1:0]         rad_next;

  always_comb begin
    prod_rnd   = prod2 + $signed(ROUND_HALF);
    prod_shr   = prod_rnd >>> FRAC_BITS;
    cand       = prod_shr[CAND_W-1:0];
    base2_w    = BASE_W'(base2);
    base3_next = (cham2 && (cand < base2_w)) ? cand : base2_w;
    rad_next   = RAD_W'(sqx2) + RAD_W'(sqy2);
  end

  logic                     ok3;
  logic signed [BASE_W-1:0] base3;
  logic [RAD_W-1:0]         rad3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (go3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (go3) begin
      ok3   <= ok2;
      base3 <= base3_next;
      rad3  <= rad_next;
    end
  end

  // ------------------------------------------------------- root pipeline
  logic [ROOT_W-1:0] root;
  logic [PAY_W-1:0]  pay_out;

  sdfc_isqrt_pipe #(
    .ROOT_W (ROOT_W),
    .PAY_W  (PAY_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_stall  (root_in_stall),
    .rad_in    (rad3),
    .pay_in    ({ok3, base3}),
    .out_valid (root_out_valid),
    .out_stall (!go_out),
    .root_out  (root),
    .pay_out   (pay_out)
  );

  // ------------------------------------------------------- output register
  // subtract the root (zero for every op but rounded union) and saturate
  logic                     ok_f;
  logic signed [BASE_W-1:0] base_f;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] sat;

  always_comb begin
    ok_f   = pay_out[PAY_W-1];
    base_f = $signed(pay_out[BASE_W-1:0]);
    diff   = DIFF_W'(base_f) - $signed({{(DIFF_W-ROOT_W){1'b0}}, root});
    if (diff > SAT_HI) begin
      sat = SAT_HI;
    end else if (diff < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go_out) begin
      res_valid <= root_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go_out) begin
      dist_out  <= ok_f ? sat[DIST_WIDTH-1:0] : '0;
      out_valid <= ok_f;
    end
  end

endmodule
